/* hw/rtl/bin_fit_with_category_conflicts_unit_assert.svh */
// assertion macros, clocked on clk and disabled while arst_n is low
`ifndef BIN_FIT_WITH_CATEGORY_CONFLICTS_UNIT_ASSERT_SVH
`define BIN_FIT_WITH_CATEGORY_CONFLICTS_UNIT_ASSERT_SVH

`define BFCC_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define BFCC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define BFCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/bfcc_pkg.sv */
package bfcc_pkg;
	localparam int MAX_ITEMS_DEF  = 64;
	localparam int CATEGORIES_DEF = 8;

	localparam int REQ_W      = 3;
	localparam int IDX_W      = 16;
	localparam int WT_W       = 16;
	localparam int CAT_W      = 3;
	localparam int POS_W      = 6;
	localparam int STAT_W     = 2;
	localparam int IDLE_W     = 18;
	localparam int CNT_OUT_W  = 7;
	localparam int CCNT_W     = 7;
	localparam int CAP_W      = 16;
	localparam int COMPAT_W   = 64;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;
	localparam int ENTRY_W    = IDX_W + WT_W + CAT_W;

	localparam logic [CAP_W-1:0]    CAP_RESET    = CAP_W'(1000);
	localparam logic [COMPAT_W-1:0] COMPAT_RESET = '1;

	localparam logic [REQ_W-1:0] REQ_FIT     = REQ_W'(0);
	localparam logic [REQ_W-1:0] REQ_ADD     = REQ_W'(1);
	localparam logic [REQ_W-1:0] REQ_REM_IDX = REQ_W'(2);
	localparam logic [REQ_W-1:0] REQ_REM_POS = REQ_W'(3);
	localparam logic [REQ_W-1:0] REQ_OPEN    = REQ_W'(4);

	localparam logic [STAT_W-1:0] ST_OK        = STAT_W'(0);
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = STAT_W'(1);
	localparam logic [STAT_W-1:0] ST_BAD_POS   = STAT_W'(2);
	localparam logic [STAT_W-1:0] ST_FULL      = STAT_W'(3);

	localparam logic [CFG_IDX_W-1:0] REG_BIN_CAPACITY  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COMPAT_MATRIX = CFG_IDX_W'(1);

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [WT_W-1:0]  wt;
		logic [CAT_W-1:0] cat;
	} entry_t;

	typedef struct packed {
		logic             clr;
		logic             inc;
		logic             dec;
		logic [CAT_W-1:0] cat;
	} cat_op_t;

	function automatic logic signed [IDLE_W-1:0] sat_idle(input logic signed [IDLE_W:0] v);
		logic signed [IDLE_W-1:0] r;
		if (v[IDLE_W] != v[IDLE_W-1]) begin
			r = v[IDLE_W] ? {1'b1, {(IDLE_W-1){1'b0}}} : {1'b0, {(IDLE_W-1){1'b1}}};
		end else begin
			r = v[IDLE_W-1:0];
		end
		return r;
	endfunction
endpackage

/* hw/rtl/bfcc_if.sv */
interface bfcc_req_if import bfcc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [IDX_W-1:0] item_index;
	logic [WT_W-1:0]  item_weight;
	logic [CAT_W-1:0] item_category;
	logic [POS_W-1:0] position;

	modport source(output valid, req_type, item_index, item_weight, item_category, position,
		input ready);
	modport sink(input valid, req_type, item_index, item_weight, item_category, position,
		output ready);
endinterface

interface bfcc_rsp_if import bfcc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     fits;
	logic [STAT_W-1:0]        status;
	logic signed [IDLE_W-1:0] idle_capacity;
	logic [CNT_OUT_W-1:0]     item_count;

	modport source(output valid, fits, status, idle_capacity, item_count, input ready);
	modport sink(input valid, fits, status, idle_capacity, item_count, output ready);
endinterface

/* hw/rtl/bfcc_ram.sv */
module bfcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* hw/rtl/bfcc_cat.sv */
module bfcc_cat import bfcc_pkg::*; #(
	parameter int CATEGORIES = CATEGORIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cat_op_t             op,
	input  logic [COMPAT_W-1:0] compat,
	input  logic [CAT_W-1:0]    q_cat,
	output logic                cat_ok
);
	logic [CCNT_W-1:0] cnt_q [CATEGORIES];
	logic              in_range;
	logic              present;
	logic              conflict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CATEGORIES; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < CATEGORIES; k++) begin
				if (op.clr) begin
					cnt_q[k] <= (op.inc && op.cat == CAT_W'(k)) ? CCNT_W'(1) : '0;
				end else if (op.cat == CAT_W'(k)) begin
					if (op.inc && cnt_q[k] != '1) begin
						cnt_q[k] <= cnt_q[k] + CCNT_W'(1);
					end else if (op.dec && cnt_q[k] != '0) begin
						cnt_q[k] <= cnt_q[k] - CCNT_W'(1);
					end
				end
			end
		end
	end

	// row q_cat of the matrix against every nonempty category
	always_comb begin
		in_range = 1'b0;
		present  = 1'b0;
		conflict = 1'b0;
		for (int k = 0; k < CATEGORIES; k++) begin
			if (q_cat == CAT_W'(k)) begin
				in_range = 1'b1;
				present  = cnt_q[k] != '0;
			end
			if (!compat[{q_cat, CAT_W'(k)}] && cnt_q[k] != '0) begin
				conflict = 1'b1;
			end
		end
		cat_ok = in_range && (present || !conflict);
	end
endmodule

/* hw/rtl/bin_fit_with_category_conflicts_unit.sv */
// fit query, add, open and unknown requests go from S_EXEC to S_RESP after accept;
// remove by position goes through S_POS_LAST and S_MOVE, or to S_RESP for a bad position;
// remove by index scans one slot read per cycle to S_MOVE on a match, else to S_RESP;
// one item in flight; the next item is accepted the cycle after its result is registered
// reset: capacity 1000, all categories compatible, empty bin, idle capacity 0
// the item memory is not cleared; slots at or above item_count are never read
`include "bin_fit_with_category_conflicts_unit_assert.svh"

module bin_fit_with_category_conflicts_unit import bfcc_pkg::*; #(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int CATEGORIES = CATEGORIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	bfcc_req_if.sink              req,
	bfcc_rsp_if.source            rsp
);
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POS_LAST,
		S_SCAN,
		S_MOVE,
		S_RESP
	} state_t;

	state_t                   state_q;
	logic [CAP_W-1:0]         capacity_q;
	logic [COMPAT_W-1:0]      compat_q;
	logic [REQ_W-1:0]         req_q;
	logic [IDX_W-1:0]         idx_q;
	logic [WT_W-1:0]          wt_q;
	logic [CAT_W-1:0]         cat_q;
	logic [POS_W-1:0]         pos_q;
	logic [WT_W-1:0]          mv_wt_q;
	logic [CAT_W-1:0]         mv_cat_q;
	logic [AW-1:0]            hit_q;
	logic [CW-1:0]            scan_q;
	logic [AW-1:0]            raddr_s1;
	logic                     rvalid_s1;
	logic signed [IDLE_W-1:0] idle_q;
	logic [CW-1:0]            count_q;
	logic                     res_fits_q;
	logic [STAT_W-1:0]        res_status_q;
	logic                     rsp_valid_q;
	logic                     rsp_fits_q;
	logic [STAT_W-1:0]        rsp_status_q;
	logic signed [IDLE_W-1:0] rsp_idle_q;
	logic [CNT_OUT_W-1:0]     rsp_count_q;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	entry_t                   ram_wentry;
	logic                     ram_re;
	logic [AW-1:0]            ram_raddr;
	logic [ENTRY_W-1:0]       ram_rdata;
	entry_t                   rd_entry;
	cat_op_t                  cat_op;
	logic                     cat_ok;

	logic [AW-1:0]            last_addr;
	logic                     full;
	logic                     pos_bad;
	logic                     wt_fits;
	logic                     rsp_free;
	logic signed [IDLE_W:0]   idle_plus;
	logic signed [IDLE_W:0]   idle_minus;
	logic signed [IDLE_W:0]   idle_open;

	assign rd_entry   = ram_rdata;
	assign last_addr  = AW'(count_q - CW'(1));
	assign full       = count_q >= CW'(MAX_ITEMS);
	assign pos_bad    = PW'(pos_q) >= PW'(count_q);
	assign wt_fits    = $signed({{(IDLE_W-WT_W){1'b0}}, wt_q}) <= idle_q;
	assign rsp_free   = !rsp_valid_q || rsp.ready;
	assign idle_plus  = {idle_q[IDLE_W-1], idle_q} + $signed({{(IDLE_W+1-WT_W){1'b0}}, mv_wt_q});
	assign idle_minus = {idle_q[IDLE_W-1], idle_q} - $signed({{(IDLE_W+1-WT_W){1'b0}}, wt_q});
	assign idle_open  = $signed({{(IDLE_W+1-CAP_W){1'b0}}, capacity_q})
		- $signed({{(IDLE_W+1-WT_W){1'b0}}, wt_q});

	assign req.ready         = state_q == S_IDLE;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.fits          = rsp_fits_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.idle_capacity = rsp_idle_q;
	assign rsp.item_count    = rsp_count_q;

	bfcc_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wentry),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	bfcc_cat #(
		.CATEGORIES(CATEGORIES)
	) u_cat (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (cat_op),
		.compat(compat_q),
		.q_cat (cat_q),
		.cat_ok(cat_ok)
	);

	// memory and category counter control
	always_comb begin
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wentry = '{idx: idx_q, wt: wt_q, cat: cat_q};
		ram_re     = 1'b0;
		ram_raddr  = last_addr;
		cat_op     = '{clr: 1'b0, inc: 1'b0, dec: 1'b0, cat: cat_q};
		unique case (state_q)
			S_EXEC: begin
				case (req_q)
					REQ_ADD: begin
						if (!full) begin
							ram_we     = 1'b1;
							ram_waddr  = AW'(count_q);
							cat_op.inc = 1'b1;
						end
					end
					REQ_OPEN: begin
						ram_we     = 1'b1;
						cat_op.clr = 1'b1;
						cat_op.inc = 1'b1;
					end
					REQ_REM_POS: begin
						ram_re    = !pos_bad;
						ram_raddr = AW'(pos_q);
					end
					default: ;
				endcase
			end
			S_POS_LAST: begin
				ram_re = 1'b1;
			end
			S_SCAN: begin
				if (rvalid_s1 && rd_entry.idx == idx_q) begin
					ram_re = 1'b1;
				end else if (!rvalid_s1 || raddr_s1 != last_addr) begin
					ram_re    = scan_q < count_q;
					ram_raddr = AW'(scan_q);
				end
			end
			S_MOVE: begin
				ram_we     = 1'b1;
				ram_waddr  = hit_q;
				ram_wentry = rd_entry;
				cat_op.dec = 1'b1;
				cat_op.cat = mv_cat_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			compat_q   <= COMPAT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_BIN_CAPACITY:  capacity_q <= cfg_wdata[CAP_W-1:0];
				REG_COMPAT_MATRIX: compat_q   <= cfg_wdata[COMPAT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idle_q       <= '0;
			count_q      <= '0;
			rvalid_s1    <= 1'b0;
			rsp_valid_q  <= 1'b0;
			res_fits_q   <= 1'b0;
			res_status_q <= ST_OK;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q        <= req.req_type;
						idx_q        <= req.item_index;
						wt_q         <= req.item_weight;
						cat_q        <= req.item_category;
						pos_q        <= req.position;
						res_fits_q   <= 1'b0;
						res_status_q <= ST_OK;
						state_q      <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					case (req_q)
						REQ_FIT: begin
							res_fits_q <= cat_ok && wt_fits;
						end
						REQ_ADD: begin
							if (full) begin
								res_status_q <= ST_FULL;
							end else begin
								count_q <= count_q + CW'(1);
								idle_q  <= sat_idle(idle_minus);
							end
						end
						REQ_OPEN: begin
							count_q <= CW'(1);
							idle_q  <= sat_idle(idle_open);
						end
						REQ_REM_POS: begin
							if (pos_bad) begin
								res_status_q <= ST_BAD_POS;
							end else begin
								hit_q   <= AW'(pos_q);
								state_q <= S_POS_LAST;
							end
						end
						REQ_REM_IDX: begin
							mv_wt_q   <= wt_q;
							mv_cat_q  <= cat_q;
							scan_q    <= '0;
							rvalid_s1 <= 1'b0;
							if (count_q == '0) begin
								res_status_q <= ST_NOT_FOUND;
							end else begin
								state_q <= S_SCAN;
							end
						end
						default: ;
					endcase
				end
				S_POS_LAST: begin
					mv_wt_q  <= rd_entry.wt;
					mv_cat_q <= rd_entry.cat;
					state_q  <= S_MOVE;
				end
				S_SCAN: begin
					if (rvalid_s1 && rd_entry.idx == idx_q) begin
						hit_q     <= raddr_s1;
						rvalid_s1 <= 1'b0;
						state_q   <= S_MOVE;
					end else if (rvalid_s1 && raddr_s1 == last_addr) begin
						rvalid_s1    <= 1'b0;
						res_status_q <= ST_NOT_FOUND;
						state_q      <= S_RESP;
					end else begin
						rvalid_s1 <= scan_q < count_q;
						raddr_s1  <= AW'(scan_q);
						if (scan_q < count_q) begin
							scan_q <= scan_q + CW'(1);
						end
					end
				end
				S_MOVE: begin
					count_q <= count_q - CW'(1);
					idle_q  <= sat_idle(idle_plus);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_fits_q   <= res_fits_q;
						rsp_status_q <= res_status_q;
						rsp_idle_q   <= idle_q;
						rsp_count_q  <= CNT_OUT_W'(count_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BFCC_ASSERT_ALWAYS(a_count_max, count_q <= CW'(MAX_ITEMS), "item count above store depth")
	`BFCC_ASSERT_IMPL(a_move_slot, state_q == S_MOVE, CW'(hit_q) < count_q, "move target beyond last slot")
	`BFCC_ASSERT_NEXT(a_move_count, state_q == S_MOVE, count_q == $past(count_q) - CW'(1), "removal did not shrink bin")
	`BFCC_ASSERT_IMPL(a_scan_addr, rvalid_s1, CW'(raddr_s1) < count_q, "scan read beyond last slot")
	`BFCC_ASSERT_NEXT(a_resp_load, state_q == S_RESP && rsp_free, rsp.valid && state_q == S_IDLE, "result not loaded")
endmodule

/* test/bin_fit_with_category_conflicts_unit_checker.sv */
module bin_fit_with_category_conflicts_unit_checker import bfcc_pkg::*; #(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int CATEGORIES = CATEGORIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	bfcc_req_if                   req,
	bfcc_rsp_if                   rsp,
	output int                    fail_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_HI = 2**(IDLE_W-1) - 1;
	localparam int IDLE_LO = -(2**(IDLE_W-1));
	localparam logic [CCNT_W-1:0] CCNT_TOP = '1;

	typedef struct packed {
		logic                     fits;
		logic [STAT_W-1:0]        status;
		logic signed [IDLE_W-1:0] idle;
		logic [CNT_OUT_W-1:0]     count;
	} bin_result_t;

	bin_result_t       expected_q[$];
	logic [CAP_W-1:0]    cap_reg;
	logic [COMPAT_W-1:0] compat_reg;
	int                  idle_now;
	entry_t              slots[MAX_ITEMS];
	logic [CCNT_W-1:0]   cat_cnt[CATEGORIES];
	int                  n_items;
	int                  errs;

	function automatic int clamp_idle(input int v);
		if (v > IDLE_HI) return IDLE_HI;
		if (v < IDLE_LO) return IDLE_LO;
		return v;
	endfunction

	function void bump_cat(input logic [CAT_W-1:0] c);
		if (c < CATEGORIES && cat_cnt[c] != CCNT_TOP) cat_cnt[c]++;
	endfunction

	function void drop_cat(input logic [CAT_W-1:0] c);
		if (c < CATEGORIES && cat_cnt[c] != '0) cat_cnt[c]--;
	endfunction

	function void take_out(input int p);
		slots[p] = slots[n_items-1];
		n_items--;
	endfunction

	function bin_result_t bin_step(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx,
		input logic [WT_W-1:0] wt, input logic [CAT_W-1:0] cat, input logic [POS_W-1:0] pos);
		bin_result_t r;
		int hit;
		int k;
		r = '0;
		hit = -1;
		case (kind)
		REQ_FIT: begin
			if (cat < CATEGORIES && int'(wt) <= idle_now) begin
				r.fits = 1'b1;
				if (cat_cnt[cat] == '0) begin
					for (k = 0; k < CATEGORIES; k++)
						if (!compat_reg[(int'(cat) * 8 + k) & 63] && cat_cnt[k] != '0)
							r.fits = 1'b0;
				end
			end
		end
		REQ_ADD: begin
			if (n_items >= MAX_ITEMS) begin
				r.status = ST_FULL;
			end else begin
				slots[n_items] = {idx, wt, cat};
				n_items++;
				idle_now = clamp_idle(idle_now - int'(wt));
				bump_cat(cat);
			end
		end
		REQ_REM_IDX: begin
			for (k = 0; k < n_items && hit < 0; k++)
				if (slots[k].idx == idx) hit = k;
			if (hit < 0) begin
				r.status = ST_NOT_FOUND;
			end else begin
				take_out(hit);
				idle_now = clamp_idle(idle_now + int'(wt));
				drop_cat(cat);
			end
		end
		REQ_REM_POS: begin
			if (int'(pos) >= n_items) begin
				r.status = ST_BAD_POS;
			end else begin
				idle_now = clamp_idle(idle_now + int'(slots[pos].wt));
				drop_cat(slots[pos].cat);
				take_out(int'(pos));
			end
		end
		REQ_OPEN: begin
			for (k = 0; k < CATEGORIES; k++) cat_cnt[k] = '0;
			slots[0] = {idx, wt, cat};
			n_items = 1;
			idle_now = clamp_idle(int'(cap_reg) - int'(wt));
			bump_cat(cat);
		end
		default: ;
		endcase
		r.idle = IDLE_W'(idle_now);
		r.count = CNT_OUT_W'(n_items);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bin_result_t want;
		if (!arst_n) begin
			expected_q.delete();
			cap_reg = CAP_RESET;
			compat_reg = COMPAT_RESET;
			idle_now = 0;
			n_items = 0;
			foreach (cat_cnt[k]) cat_cnt[k] = '0;
			errs = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$error("result item with no request outstanding");
					errs++;
				end else begin
					want = expected_q.pop_front();
					if (rsp.fits !== want.fits) begin
						$error("fits: expected %0d, got %0d", want.fits, rsp.fits);
						errs++;
					end
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errs++;
					end
					if (rsp.idle_capacity !== want.idle) begin
						$error("idle_capacity: expected %0d, got %0d",
							$signed(want.idle), $signed(rsp.idle_capacity));
						errs++;
					end
					if (rsp.item_count !== want.count) begin
						$error("item_count: expected %0d, got %0d", want.count, rsp.item_count);
						errs++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
				REG_BIN_CAPACITY: cap_reg = cfg_wdata[CAP_W-1:0];
				REG_COMPAT_MATRIX: compat_reg = cfg_wdata[COMPAT_W-1:0];
				default: ;
				endcase
			end
			if (req.valid && req.ready)
				expected_q = {expected_q, bin_step(req.req_type, req.item_index,
					req.item_weight, req.item_category, req.position)};
		end
		fail_count <= errs;
		pending <= expected_q.size();
	end
endmodule

/* test/bin_fit_with_category_conflicts_unit_test.sv */
module bin_fit_with_category_conflicts_unit_test import bfcc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT      = 3000;
	localparam int RANDOM_PER_PHASE = 190;
	localparam int REQ_TOP          = 2**REQ_W - 1;
	localparam int REQ_FIRST_UNUSED = int'(REQ_OPEN) + 1;
	localparam int CAT_TOP          = 2**CAT_W - 1;
	localparam int POS_TOP          = 2**POS_W - 1;

	typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_SPARSE} ready_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	logic             req_valid = 1'b0;
	logic [REQ_W-1:0] req_kind = '0;
	logic [IDX_W-1:0] req_idx = '0;
	logic [WT_W-1:0]  req_wt = '0;
	logic [CAT_W-1:0] req_cat = '0;
	logic [POS_W-1:0] req_pos = '0;
	logic             rsp_ready = 1'b0;

	int                   fail_count;
	int                   pending;
	int                   burst_left = 0;
	int                   items_sent = 0;
	int                   quiet_cycles = 0;
	int                   mode_left = 0;
	int                   stall_tick = 0;
	ready_mode_t          ready_mode = RDY_ALWAYS;
	logic [CNT_OUT_W-1:0] seen_count = '0;

	bfcc_req_if req_ch();
	bfcc_rsp_if rsp_ch();

	assign req_ch.valid = req_valid;
	assign req_ch.req_type = req_kind;
	assign req_ch.item_index = req_idx;
	assign req_ch.item_weight = req_wt;
	assign req_ch.item_category = req_cat;
	assign req_ch.position = req_pos;
	assign rsp_ch.ready = rsp_ready;

	always #6 clk = ~clk;

	bin_fit_with_category_conflicts_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	bin_fit_with_category_conflicts_unit_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(40, 300);
		end
		mode_left--;
		stall_tick++;
		case (ready_mode)
		RDY_ALWAYS: rsp_ready = 1'b1;
		RDY_COIN: rsp_ready = 1'($urandom_range(0, 1));
		RDY_PERIODIC: rsp_ready = (stall_tick % 9) < 6;
		default: rsp_ready = $urandom_range(0, 4) == 0;
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) seen_count = rsp_ch.item_count;
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("** bin_fit_with_category_conflicts_unit: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_req(input int kind, input int idx, input int wt, input int cat,
		input int pos);
		@(negedge clk);
		if (burst_left == 0) begin
			req_valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		req_kind = REQ_W'(kind);
		req_idx = IDX_W'(idx);
		req_wt = WT_W'(wt);
		req_cat = CAT_W'(cat);
		req_pos = POS_W'(pos);
		req_valid = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		if (kind <= int'(REQ_OPEN)) items_sent++;
	endtask

	task automatic quiesce();
		@(negedge clk);
		req_valid = 1'b0;
		burst_left = 0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = r;
		cfg_wdata = d;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic int pick_index();
		return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 15) : $urandom_range(0, 65535);
	endfunction

	function automatic int pick_weight();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(0, 300);
		if (r < 90) return $urandom_range(60000, 65535);
		return $urandom_range(0, 65535);
	endfunction

	function automatic int pick_pos();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(0, POS_TOP)
			: $urandom_range(0, seen_count);
	endfunction

	task automatic run_sequence();
		int shape;
		int op;
		shape = $urandom_range(0, 9);
		if (shape == 9) begin
			repeat (5)
				send_req($urandom_range(0, REQ_TOP), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, CAT_TOP), $urandom_range(0, POS_TOP));
			return;
		end
		send_req(REQ_OPEN, pick_index(), pick_weight(), $urandom_range(0, CAT_TOP), 0);
		if (shape == 8) begin
			repeat ($urandom_range(MAX_ITEMS_DEF, MAX_ITEMS_DEF + 3))
				send_req(REQ_ADD, pick_index(), $urandom_range(0, 50), $urandom_range(0, CAT_TOP), 0);
			repeat (4) send_req(REQ_REM_POS, 0, 0, 0, $urandom_range(0, POS_TOP));
			return;
		end
		repeat ($urandom_range(3, 25)) begin
			op = $urandom_range(0, 99);
			if (op < 30)
				send_req(REQ_FIT, pick_index(), pick_weight(), $urandom_range(0, CAT_TOP), 0);
			else if (op < 55)
				send_req(REQ_ADD, pick_index(), pick_weight(), $urandom_range(0, CAT_TOP), 0);
			else if (op < 72)
				send_req(REQ_REM_IDX, pick_index(), pick_weight(), $urandom_range(0, CAT_TOP), 0);
			else if (op < 87)
				send_req(REQ_REM_POS, pick_index(), pick_weight(), $urandom_range(0, CAT_TOP),
					pick_pos());
			else if (op < 93)
				send_req($urandom_range(REQ_FIRST_UNUSED, REQ_TOP), pick_index(), pick_weight(),
					$urandom_range(0, CAT_TOP), $urandom_range(0, POS_TOP));
			else
				send_req(REQ_OPEN, pick_index(), pick_weight(), $urandom_range(0, CAT_TOP), 0);
		end
	endtask

	initial begin
		int ph;
		int k;
		int goal;
		logic [CAP_W-1:0]    cap;
		logic [COMPAT_W-1:0] compat;
		logic [CAT_W-1:0]    pump_cat;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty bin after reset
		send_req(REQ_FIT, 0, 0, 0, 0);
		send_req(REQ_FIT, 0, 1, 7, 0);
		send_req(REQ_REM_IDX, 0, 0, 0, 0);
		send_req(REQ_REM_POS, 0, 0, 0, 0);
		// heavy adds drive idle capacity to its negative limit
		send_req(REQ_ADD, 16'hFFFF, 16'hFFFF, 7, 0);
		send_req(REQ_ADD, 0, 16'hFFFF, 0, 0);
		send_req(REQ_ADD, 1, 16'hFFFF, 0, 0);
		send_req(REQ_FIT, 0, 0, 3, 0);
		send_req(REQ_REM_POS, 0, 0, 0, POS_TOP);
		send_req(REQ_REM_POS, 0, 0, 0, 0);
		send_req(REQ_REM_IDX, 0, 16'hFFFF, 0, 0);
		send_req(REQ_REM_IDX, 16'hFFFF, 0, 5, 0);
		for (k = REQ_FIRST_UNUSED; k <= REQ_TOP; k++)
			send_req(k, 16'hFFFF, 16'hFFFF, CAT_TOP, POS_TOP);
		// removals with heavy weights drive it to its positive limit
		send_req(REQ_OPEN, 16'hFFFF, 0, 7, 0);
		send_req(REQ_REM_IDX, 16'hFFFF, 16'hFFFF, 7, 0);
		send_req(REQ_ADD, 2, 0, 1, 0);
		send_req(REQ_REM_IDX, 2, 16'hFFFF, 3, 0);
		send_req(REQ_FIT, 0, 16'hFFFF, 2, 0);
		send_req(REQ_OPEN, 3, 16'hFFFF, 0, 0);
		send_req(REQ_FIT, 0, 0, 0, 0);
		send_req(REQ_ADD, 16'hAAAA, 16'h5555, 2, 6'h2A);
		send_req(REQ_ADD, 16'h5555, 16'hAAAA, 5, 6'h15);
		send_req(REQ_REM_POS, 0, 0, 0, 1);

		for (ph = 1; ph <= 5; ph++) begin
			quiesce();
			case (ph)
			1: begin
				cap = '1;
				compat = '0;
			end
			2: begin
				cap = '0;
				compat = '1;
			end
			3: begin
				cap = CAP_W'($urandom);
				compat = {$urandom, $urandom};
			end
			4: begin
				cap = CAP_W'($urandom_range(500, 5000));
				compat = {$urandom, $urandom} & {$urandom, $urandom};
			end
			default: begin
				cap = CAP_RESET;
				compat = {$urandom, $urandom} | {$urandom, $urandom};
			end
			endcase
			write_reg(REG_BIN_CAPACITY, CFG_DATA_W'(cap));
			write_reg(REG_COMPAT_MATRIX, CFG_DATA_W'(compat));
			goal = items_sent + RANDOM_PER_PHASE;
			if (ph == 1) begin
				// removals that name another category leave this one counting up to saturation
				pump_cat = CAT_W'($urandom_range(0, CAT_TOP));
				send_req(REQ_OPEN, 0, 0, pump_cat, 0);
				repeat (3) begin
					for (k = 1; k < MAX_ITEMS_DEF; k++)
						send_req(REQ_ADD, k, $urandom_range(0, 20), pump_cat, 0);
					send_req(REQ_ADD, 0, 0, pump_cat, 0);
					send_req(REQ_FIT, 0, 0, pump_cat, 0);
					send_req(REQ_FIT, 0, 0, CAT_W'(pump_cat + 1), 0);
					for (k = 1; k < MAX_ITEMS_DEF; k++)
						send_req(REQ_REM_IDX, k, 0, CAT_W'(pump_cat + 1), 0);
				end
				send_req(REQ_FIT, 0, 0, pump_cat, 0);
			end
			while (items_sent < goal) run_sequence();
		end

		quiesce();
		repeat (80) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** bin_fit_with_category_conflicts_unit: PASSED **");
		else
			$display("** bin_fit_with_category_conflicts_unit: FAILED **");
		$finish;
	end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/bfcc_pkg.sv
hw/rtl/bfcc_if.sv
hw/rtl/bfcc_ram.sv
hw/rtl/bfcc_cat.sv
hw/rtl/bin_fit_with_category_conflicts_unit.sv
test/bin_fit_with_category_conflicts_unit_checker.sv
test/bin_fit_with_category_conflicts_unit_test.sv
